@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define CRCLD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crcld check failed");

// next-cycle implication, off while reset is held
`define CRCLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crcld check failed");

`endif

@@ src/crcld_pkg.sv @@
// types and constants of the serial crc long division block
package crcld_pkg;

    localparam int unsigned REM_W  = 32;
    localparam int unsigned KLEN_W = 6;
    localparam int unsigned CIDX_W = 2;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned QPTR_W  = 2;
    localparam int unsigned QCNT_W  = 3;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd4;
    localparam logic [REM_W-1:0]  GEN_RESET  = 32'd5;
    localparam logic              MODE_RESET = 1'b0;

    localparam logic [CIDX_W-1:0] CFG_KEY_LENGTH    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GENERATOR_LOW = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MODE          = 2'd2;

    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;

    localparam logic KIND_QUOTIENT  = 1'b0;
    localparam logic KIND_REMAINDER = 1'b1;

    typedef struct packed {
        logic data_bit;
        logic final_bit;
    } t_in_word;

    typedef struct packed {
        logic             kind;
        logic             quotient_bit;
        logic [REM_W-1:0] remainder;
        logic             error_found;
        logic             run_end;
    } t_out_word;

    typedef struct packed {
        logic [KLEN_W-1:0] key_length;
        logic [REM_W-1:0]  generator_low;
        logic              mode;
    } t_cfg;

    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_q_head;

endpackage

@@ src/crcld_front.sv @@
// input side: accepts words into a short queue ahead of the division engine
module crcld_front import crcld_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_word,
    output t_q_head  o_head,
    input  logic     i_pop
);

    t_in_word            r_mem [Q_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                push;
    logic                pop;

    assign o_in_stall   = (r_count == QCNT_W'(Q_DEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_in_word;
        end
    end

endmodule

@@ src/crcld_back.sv @@
// division engine: shift-xor step, zero flush and output register
module crcld_back import crcld_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic [1:0] {
        PH_RUN   = 2'b01,
        PH_FLUSH = 2'b10
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [KLEN_W-1:0]  r_taken, n_taken;
    logic [KLEN_W-1:0]  r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic [KLEN_W-1:0]  rbits;
    logic [REM_W-1:0]   mask;
    logic               full;
    logic               q;
    logic               sh_bit;
    logic [REM_W-1:0]   shifted;
    logic               out_free;

    // saturated remainder width 1..32
    always_comb begin
        priority if (i_cfg.key_length < KLEN_W'(2)) begin
            rbits = KLEN_W'(1);
        end else if (i_cfg.key_length > KLEN_W'(33)) begin
            rbits = KLEN_W'(32);
        end else begin
            rbits = i_cfg.key_length - KLEN_W'(1);
        end
    end

    assign mask     = {REM_W{1'b1}} >> (KLEN_W'(REM_W) - rbits);
    assign full     = (r_taken >= rbits);
    assign q        = r_rem[5'(rbits - KLEN_W'(1))];
    assign sh_bit   = (r_phase == PH_RUN) ? i_head.word.data_bit : 1'b0;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        shifted = {r_rem[REM_W-2:0], sh_bit} & mask;
        if (full && q) begin
            shifted = shifted ^ (i_cfg.generator_low & mask);
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_rem       = r_rem;
        n_taken     = r_taken;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        unique case (r_phase)
            PH_RUN: begin
                if (i_head.valid && out_free) begin
                    o_pop = 1'b1;
                    n_rem = shifted;
                    if (!full) begin
                        n_taken = r_taken + KLEN_W'(1);
                    end else begin
                        n_out              = '0;
                        n_out.kind         = KIND_QUOTIENT;
                        n_out.quotient_bit = q;
                        n_out.run_end      = !i_head.word.final_bit;
                        n_out_valid        = 1'b1;
                    end
                    if (i_head.word.final_bit) begin
                        n_phase = PH_FLUSH;
                        n_cnt   = (i_cfg.mode == MODE_CHECK) ? '0 : rbits;
                    end
                end
            end
            PH_FLUSH: begin
                if (out_free) begin
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - KLEN_W'(1);
                        n_rem = shifted;
                        if (!full) begin
                            n_taken = r_taken + KLEN_W'(1);
                        end else begin
                            n_out              = '0;
                            n_out.kind         = KIND_QUOTIENT;
                            n_out.quotient_bit = q;
                            n_out_valid        = 1'b1;
                        end
                    end else begin
                        n_out             = '0;
                        n_out.kind        = KIND_REMAINDER;
                        n_out.remainder   = r_rem;
                        n_out.error_found = (i_cfg.mode == MODE_CHECK) && (r_rem != '0);
                        n_out.run_end     = 1'b1;
                        n_out_valid       = 1'b1;
                        n_rem             = '0;
                        n_taken           = '0;
                        n_phase           = PH_RUN;
                    end
                end
            end
            default: begin
                n_phase = PH_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RUN;
            r_rem       <= '0;
            r_taken     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_rem       <= n_rem;
            r_taken     <= n_taken;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ src/crc_long_division_serial.sv @@
// top level of the bit-serial crc long division block
//
//  port group   direction  word         handshake
//  i_in_*       in         t_in_word    i_in_valid / o_in_stall
//  o_out_*      out        t_out_word   o_out_valid / i_out_stall
//  i_cfg_*      in         32-bit data  i_cfg_we, index i_cfg_idx
//
// one input word per cycle while no final bit is seen and the output is not
// stalled; a four-deep queue decouples input from the engine
// a final word is followed by one zero shift per remainder bit (generate mode
// only) and then the remainder word, all through one shift-xor unit
// synchronous active-low reset clears queue, engine state and output valid
// an output stall holds the output register and pauses the engine
module crc_long_division_serial import crcld_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [REM_W-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_q_head head;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_length    <= KLEN_RESET;
            r_cfg.generator_low <= GEN_RESET;
            r_cfg.mode          <= MODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_LENGTH:    r_cfg.key_length    <= i_cfg_data[KLEN_W-1:0];
                CFG_GENERATOR_LOW: r_cfg.generator_low <= i_cfg_data;
                CFG_MODE:          r_cfg.mode          <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    crcld_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_head     (head),
        .i_pop      (pop)
    );

    crcld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

@@ src/crcld_checker.sv @@
// port-level checker for the crc long division block, with its bind
`include "assert_macros.svh"

module crcld_checker import crcld_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_word         o_out_word
);

    `CRCLD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `CRCLD_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_word))
    `CRCLD_ASSERT_NOW(a_rem_ends_run, o_out_valid && (o_out_word.kind == KIND_REMAINDER),
                      o_out_word.run_end && !o_out_word.quotient_bit)
    `CRCLD_ASSERT_NOW(a_quot_clean, o_out_valid && (o_out_word.kind == KIND_QUOTIENT),
                      (o_out_word.remainder == '0) && !o_out_word.error_found)

endmodule

bind crc_long_division_serial crcld_checker u_crcld_checker (.*);
